/* hdl/kgq_pkg.sv */
// ----------------------------------------------------------------------------
// kgq_pkg
// Shared types and constants of the keypoint grid area query block.
// ----------------------------------------------------------------------------
package kgq_pkg;

    // default sizes
    localparam int MAX_KEYS_DEF  = 1024;
    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 48;
    localparam int MAX_HITS_DEF  = 64;

    // shared multiplier operand and result widths
    localparam int OPA_W  = 19;
    localparam int OPB_W  = 17;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int CELL_W = 18;

    // function codes
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] REG_SCALE_X  = 2'd2;
    localparam logic [1:0] REG_SCALE_Y  = 2'd3;

    // one result item
    typedef struct packed {
        logic       last;
        logic       truncated;
        logic [9:0] hit_index;
        logic       hit_valid;
        logic [5:0] cell_y;
        logic [5:0] cell_x;
        logic       store_full;
        logic       in_grid;
        logic [9:0] key_index;
    } res_t;

endpackage

/* hdl/kgq_mul.sv */
// ----------------------------------------------------------------------------
// kgq_mul
// Shared registered multiplier with Q20 floor, ceil and rounding of the product.
// ----------------------------------------------------------------------------
module kgq_mul (
    input  logic                               aclk,
    input  logic signed [kgq_pkg::OPA_W-1:0]   op_a,
    input  logic signed [kgq_pkg::OPB_W-1:0]   op_b,
    output logic signed [kgq_pkg::PROD_W-1:0]  prod,
    output logic signed [kgq_pkg::CELL_W-1:0]  flr,
    output logic signed [kgq_pkg::CELL_W-1:0]  cel,
    output logic signed [kgq_pkg::CELL_W-1:0]  rnd
);

    localparam int PW = kgq_pkg::PROD_W;

    logic signed [PW-1:0] prod_reg;
    logic signed [PW:0]   p_ext;
    logic signed [PW:0]   flr_full;
    logic signed [PW:0]   cel_full;
    logic        [PW:0]   mag;
    logic        [PW:0]   mag_rnd;
    logic        [PW:0]   rnd_full;

    // product register
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod  = prod_reg;
    assign p_ext = {prod_reg[PW-1], prod_reg};

    // floor and ceil on 20 fraction bits
    assign flr_full = p_ext >>> 20;
    assign cel_full = (p_ext + (PW+1)'(20'hFFFFF)) >>> 20;

    // round half away from zero
    assign mag      = prod_reg[PW-1] ? (PW+1)'(-p_ext) : (PW+1)'(p_ext);
    assign mag_rnd  = (mag + (PW+1)'(20'h80000)) >> 20;
    assign rnd_full = prod_reg[PW-1] ? (PW+1)'(-mag_rnd) : mag_rnd;

    assign flr = flr_full[kgq_pkg::CELL_W-1:0];
    assign cel = cel_full[kgq_pkg::CELL_W-1:0];
    assign rnd = rnd_full[kgq_pkg::CELL_W-1:0];

endmodule

/* hdl/keypoint_grid_area_query.sv */
// ----------------------------------------------------------------------------
// keypoint_grid_area_query
// Uniform grid index of image keypoints with add, clear and area query.
// ----------------------------------------------------------------------------
// One item is handled at a time by a sequencer around a single shared
// multiplier. A clear sweeps the cell table, one cell a cycle; the same
// sweep runs after reset before the first item is taken. An add scales the
// key position and forms the cell address on the multiplier, then does a
// read-modify-write of the cell table, skipped for a key outside the grid;
// a full store skips all of this. A query sets up the cell window, walks
// the list of each cell in it and sends each hit when the next is found,
// the last in the final item; a stalled output holds the walk.
// ----------------------------------------------------------------------------
module keypoint_grid_area_query #(
    parameter int MAX_KEYS  = kgq_pkg::MAX_KEYS_DEF,
    parameter int GRID_COLS = kgq_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = kgq_pkg::GRID_ROWS_DEF,
    parameter int MAX_HITS  = kgq_pkg::MAX_HITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // key_x, key_y, key_level, query_x, query_y, radius, min_level, max_level
    input  logic [95:0] s_tdata,
    // func
    input  logic [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // key_index, in_grid, store_full, cell_x, cell_y, hit_valid, hit_index,
    // truncated
    output logic [39:0] m_tdata,
    output logic        m_tlast
);

    localparam int NCELLS = GRID_COLS * GRID_ROWS;
    localparam int KW     = $clog2(MAX_KEYS);
    localparam int CAW    = $clog2(NCELLS);
    localparam int CW     = $clog2(GRID_COLS);
    localparam int RW     = $clog2(GRID_ROWS);
    localparam int NW     = $clog2(MAX_HITS + 1);
    localparam int OA     = kgq_pkg::OPA_W;
    localparam int OB     = kgq_pkg::OPB_W;
    localparam int QW     = kgq_pkg::CELL_W;

    // sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SWEEP = 5'd1;
    localparam logic [4:0] ST_EMIT  = 5'd2;
    localparam logic [4:0] ST_A_MX  = 5'd3;
    localparam logic [4:0] ST_A_MY  = 5'd4;
    localparam logic [4:0] ST_A_C0  = 5'd5;
    localparam logic [4:0] ST_A_C1  = 5'd6;
    localparam logic [4:0] ST_A_H   = 5'd7;
    localparam logic [4:0] ST_Q_M0  = 5'd8;
    localparam logic [4:0] ST_Q_M1  = 5'd9;
    localparam logic [4:0] ST_Q_M2  = 5'd10;
    localparam logic [4:0] ST_Q_M3  = 5'd11;
    localparam logic [4:0] ST_Q_M4  = 5'd12;
    localparam logic [4:0] ST_Q_M5  = 5'd13;
    localparam logic [4:0] ST_CELL  = 5'd14;
    localparam logic [4:0] ST_HEAD  = 5'd15;
    localparam logic [4:0] ST_KEY   = 5'd16;
    localparam logic [4:0] ST_FIN   = 5'd17;

    localparam logic signed [QW-1:0] COLS_S = QW'(GRID_COLS);
    localparam logic signed [QW-1:0] ROWS_S = QW'(GRID_ROWS);

    // configuration
    logic signed [15:0] org_x_reg, org_y_reg;
    logic        [15:0] scl_x_reg, scl_y_reg;

    // control
    logic [4:0]   state_reg;
    logic [CAW-1:0] sweep_reg;
    logic         clr_report_reg;
    logic [KW:0]  key_count_reg;
    kgq_pkg::res_t res_reg;

    // latched item
    logic [15:0]  kx_reg, ky_reg, qx_reg, qy_reg, rad_reg;
    logic [2:0]   klvl_reg, minl_reg;
    logic [3:0]   maxl_reg;
    logic [KW-1:0] idx_reg;

    // add working values
    logic signed [QW-1:0] px_reg, py_reg;
    logic [CAW-1:0] c_reg;

    // query window and walk
    logic [CW-1:0]  x0_reg, x1_reg, ix_reg;
    logic [RW-1:0]  y0_reg, y1_reg, iy_reg;
    logic           win_bad_reg;
    logic [CAW-1:0] base_reg;
    logic [KW-1:0]  node_reg;
    logic [KW-1:0]  pend_reg;
    logic           pend_v_reg;
    logic           more_reg;
    logic [NW-1:0]  n_reg;

    // output register
    logic          m_valid_reg;
    kgq_pkg::res_t out_reg;

    // memories
    logic [KW:0]   head_mem [NCELLS];
    logic [KW-1:0] tail_mem [NCELLS];
    logic [34:0]   key_mem  [MAX_KEYS];
    logic [KW-1:0] link_mem [MAX_KEYS];
    logic [KW:0]   head_rd_reg;
    logic [KW-1:0] tail_rd_reg;
    logic [34:0]   key_rd_reg;
    logic [KW-1:0] link_rd_reg;

    // shared multiplier
    logic signed [OA-1:0] mul_a;
    logic signed [OB-1:0] mul_b;
    logic signed [kgq_pkg::PROD_W-1:0] mul_prod;
    logic signed [QW-1:0] mul_flr, mul_cel, mul_rnd;

    kgq_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod),
        .flr  (mul_flr),
        .cel  (mul_cel),
        .rnd  (mul_rnd)
    );

    // input field split
    logic [15:0] in_kx, in_ky, in_qx, in_qy, in_rad;
    logic [2:0]  in_klvl, in_minl;
    logic [3:0]  in_maxl;
    assign in_kx   = s_tdata[15:0];
    assign in_ky   = s_tdata[31:16];
    assign in_klvl = s_tdata[34:32];
    assign in_qx   = s_tdata[50:35];
    assign in_qy   = s_tdata[66:51];
    assign in_rad  = s_tdata[82:67];
    assign in_minl = s_tdata[85:83];
    assign in_maxl = s_tdata[89:86];

    logic accept;
    logic out_free;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // offsets from the grid origin
    logic signed [OA-1:0] kdx, kdy, qdx, qdy, rad_s;
    assign kdx   = OA'($signed({3'b0, kx_reg})) - OA'(org_x_reg);
    assign kdy   = OA'($signed({3'b0, ky_reg})) - OA'(org_y_reg);
    assign qdx   = OA'($signed({3'b0, qx_reg})) - OA'(org_x_reg);
    assign qdy   = OA'($signed({3'b0, qy_reg})) - OA'(org_y_reg);
    assign rad_s = OA'($signed({3'b0, rad_reg}));

    // multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_A_MX: begin
                mul_a = kdx;
                mul_b = OB'($signed({1'b0, scl_x_reg}));
            end
            ST_A_MY: begin
                mul_a = kdy;
                mul_b = OB'($signed({1'b0, scl_y_reg}));
            end
            ST_A_C0: begin
                mul_a = OA'(px_reg);
                mul_b = OB'(GRID_ROWS);
            end
            ST_Q_M0: begin
                mul_a = qdx - rad_s;
                mul_b = OB'($signed({1'b0, scl_x_reg}));
            end
            ST_Q_M1: begin
                mul_a = qdx + rad_s;
                mul_b = OB'($signed({1'b0, scl_x_reg}));
            end
            ST_Q_M2: begin
                mul_a = qdy - rad_s;
                mul_b = OB'($signed({1'b0, scl_y_reg}));
            end
            ST_Q_M3: begin
                mul_a = qdy + rad_s;
                mul_b = OB'($signed({1'b0, scl_y_reg}));
            end
            ST_Q_M4: begin
                mul_a = OA'($signed({1'b0, x0_reg}));
                mul_b = OB'(GRID_ROWS);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // keypoint test during the walk
    logic [2:0]         kv_lvl;
    logic signed [16:0] kv_dx, kv_dy;
    logic [16:0]        kv_ax, kv_ay;
    logic               lvl_ok, hit;
    assign kv_lvl = key_rd_reg[34:32];
    assign kv_dx  = $signed({1'b0, key_rd_reg[15:0]}) - $signed({1'b0, qx_reg});
    assign kv_dy  = $signed({1'b0, key_rd_reg[31:16]}) - $signed({1'b0, qy_reg});
    assign kv_ax  = kv_dx[16] ? 17'(-kv_dx) : 17'(kv_dx);
    assign kv_ay  = kv_dy[16] ? 17'(-kv_dy) : 17'(kv_dy);
    assign lvl_ok = (kv_lvl >= minl_reg) && (maxl_reg[3] || ({1'b0, kv_lvl} <= maxl_reg));
    assign hit    = lvl_ok && (kv_ax < {1'b0, rad_reg}) && (kv_ay < {1'b0, rad_reg});

    // last cell of the window
    logic row_end, col_end;
    assign row_end = (iy_reg == y1_reg);
    assign col_end = (ix_reg == x1_reg);

    // memory control
    logic           head_we, head_re, tail_we, key_we, link_we, key_re;
    logic [CAW-1:0] head_wa, head_ra;
    logic [KW:0]    head_wd;
    logic [KW-1:0]  key_ra, link_wa;
    logic [CAW-1:0] cell_a1;
    assign cell_a1 = CAW'(mul_prod) + CAW'(py_reg);

    always_comb begin
        head_we = 1'b0;
        head_re = 1'b0;
        tail_we = 1'b0;
        key_we  = 1'b0;
        link_we = 1'b0;
        key_re  = 1'b0;
        head_wa = c_reg;
        head_ra = base_reg + CAW'(iy_reg);
        head_wd = {1'b1, idx_reg};
        key_ra  = link_rd_reg;
        link_wa = tail_rd_reg;
        case (state_reg)
            ST_SWEEP: begin
                head_we = 1'b1;
                head_wa = sweep_reg;
                head_wd = '0;
            end
            ST_IDLE: begin
                key_we = accept && (s_tuser == kgq_pkg::FUNC_ADD)
                         && (key_count_reg < (KW+1)'(MAX_KEYS));
            end
            ST_A_C1: begin
                head_re = 1'b1;
                head_ra = cell_a1;
            end
            ST_A_H: begin
                tail_we = 1'b1;
                head_we = !head_rd_reg[KW];
                link_we = head_rd_reg[KW];
            end
            ST_CELL: begin
                head_re = 1'b1;
            end
            ST_HEAD: begin
                key_re = head_rd_reg[KW];
                key_ra = head_rd_reg[KW-1:0];
            end
            ST_KEY: begin
                key_re = !(hit && (n_reg == NW'(MAX_HITS)))
                         && !(hit && pend_v_reg && !out_free)
                         && (node_reg != tail_rd_reg);
            end
            default: begin
                head_we = 1'b0;
            end
        endcase
    end

    // cell table: head with valid bit, and tail
    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        if (head_re) head_rd_reg <= head_mem[head_ra];
    end

    always_ff @(posedge aclk) begin
        if (tail_we) tail_mem[c_reg] <= idx_reg;
        if (head_re) tail_rd_reg <= tail_mem[head_ra];
    end

    // keypoint store and list links
    always_ff @(posedge aclk) begin
        if (key_we) key_mem[key_count_reg[KW-1:0]] <= {in_klvl, in_ky, in_kx};
        if (key_re) key_rd_reg <= key_mem[key_ra];
    end

    always_ff @(posedge aclk) begin
        if (link_we) link_mem[link_wa] <= idx_reg;
        if (key_re) link_rd_reg <= link_mem[key_ra];
    end

    // output push from the walk or the emit state
    logic          push;
    kgq_pkg::res_t push_res;
    always_comb begin
        push     = 1'b0;
        push_res = res_reg;
        if (state_reg == ST_EMIT) begin
            push = out_free;
        end else if (state_reg == ST_KEY) begin
            push = hit && pend_v_reg && out_free && (n_reg != NW'(MAX_HITS));
            push_res = '0;
            push_res.hit_valid = 1'b1;
            push_res.hit_index = 10'(pend_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (push) out_reg <= push_res;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            scl_x_reg <= 16'd6554;
            scl_y_reg <= 16'd6554;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                kgq_pkg::REG_ORIGIN_X: org_x_reg <= cfg_data;
                kgq_pkg::REG_ORIGIN_Y: org_y_reg <= cfg_data;
                kgq_pkg::REG_SCALE_X:  scl_x_reg <= cfg_data;
                kgq_pkg::REG_SCALE_Y:  scl_y_reg <= cfg_data;
                default:               org_x_reg <= org_x_reg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            sweep_reg      <= '0;
            clr_report_reg <= 1'b0;
            key_count_reg  <= '0;
            pend_v_reg     <= 1'b0;
            more_reg       <= 1'b0;
            n_reg          <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        kx_reg   <= in_kx;
                        ky_reg   <= in_ky;
                        klvl_reg <= in_klvl;
                        qx_reg   <= in_qx;
                        qy_reg   <= in_qy;
                        rad_reg  <= in_rad;
                        minl_reg <= in_minl;
                        maxl_reg <= in_maxl;
                        idx_reg  <= key_count_reg[KW-1:0];
                        res_reg  <= '0;
                        res_reg.last <= 1'b1;
                        pend_v_reg <= 1'b0;
                        more_reg   <= 1'b0;
                        n_reg      <= '0;
                        case (s_tuser)
                            kgq_pkg::FUNC_CLEAR: begin
                                sweep_reg      <= '0;
                                clr_report_reg <= 1'b1;
                                state_reg      <= ST_SWEEP;
                            end
                            kgq_pkg::FUNC_ADD: begin
                                if (key_count_reg >= (KW+1)'(MAX_KEYS)) begin
                                    res_reg.store_full <= 1'b1;
                                    state_reg <= ST_EMIT;
                                end else begin
                                    key_count_reg <= key_count_reg + 1'b1;
                                    state_reg <= ST_A_MX;
                                end
                            end
                            kgq_pkg::FUNC_QUERY: state_reg <= ST_Q_M0;
                            default:             state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_SWEEP: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == CAW'(NCELLS - 1)) begin
                        state_reg <= clr_report_reg ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (out_free) state_reg <= ST_IDLE;
                end
                // add: cell coordinates, then the list append
                ST_A_MX: state_reg <= ST_A_MY;
                ST_A_MY: begin
                    px_reg    <= mul_rnd;
                    state_reg <= ST_A_C0;
                end
                ST_A_C0: begin
                    py_reg <= mul_rnd;
                    res_reg.key_index <= 10'(idx_reg);
                    if (px_reg >= 0 && px_reg < COLS_S && mul_rnd >= 0 && mul_rnd < ROWS_S)
                    begin
                        state_reg <= ST_A_C1;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_A_C1: begin
                    c_reg     <= cell_a1;
                    state_reg <= ST_A_H;
                end
                ST_A_H: begin
                    res_reg.in_grid <= 1'b1;
                    res_reg.cell_x  <= 6'(px_reg);
                    res_reg.cell_y  <= 6'(py_reg);
                    state_reg <= ST_EMIT;
                end
                // query: window bounds, clamped to the grid
                ST_Q_M0: begin
                    win_bad_reg <= 1'b0;
                    state_reg   <= ST_Q_M1;
                end
                ST_Q_M1: begin
                    x0_reg <= (mul_flr < 0) ? '0 : CW'(mul_flr);
                    if (mul_flr >= COLS_S) win_bad_reg <= 1'b1;
                    state_reg <= ST_Q_M2;
                end
                ST_Q_M2: begin
                    x1_reg <= (mul_cel > COLS_S - 1) ? CW'(GRID_COLS - 1) : CW'(mul_cel);
                    if (mul_cel < 0) win_bad_reg <= 1'b1;
                    state_reg <= ST_Q_M3;
                end
                ST_Q_M3: begin
                    y0_reg <= (mul_flr < 0) ? '0 : RW'(mul_flr);
                    if (mul_flr >= ROWS_S) win_bad_reg <= 1'b1;
                    state_reg <= ST_Q_M4;
                end
                ST_Q_M4: begin
                    y1_reg <= (mul_cel > ROWS_S - 1) ? RW'(GRID_ROWS - 1) : RW'(mul_cel);
                    if (win_bad_reg || mul_cel < 0) state_reg <= ST_FIN;
                    else state_reg <= ST_Q_M5;
                end
                ST_Q_M5: begin
                    base_reg  <= CAW'(mul_prod);
                    ix_reg    <= x0_reg;
                    iy_reg    <= y0_reg;
                    state_reg <= ST_CELL;
                end
                // walk the cell lists
                ST_CELL: state_reg <= ST_HEAD;
                ST_HEAD: begin
                    node_reg <= head_rd_reg[KW-1:0];
                    if (head_rd_reg[KW]) begin
                        state_reg <= ST_KEY;
                    end else if (!row_end) begin
                        iy_reg <= iy_reg + 1'b1;
                        state_reg <= ST_CELL;
                    end else if (!col_end) begin
                        iy_reg   <= y0_reg;
                        ix_reg   <= ix_reg + 1'b1;
                        base_reg <= base_reg + CAW'(GRID_ROWS);
                        state_reg <= ST_CELL;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_KEY: begin
                    if (hit && (n_reg == NW'(MAX_HITS))) begin
                        more_reg  <= 1'b1;
                        state_reg <= ST_FIN;
                    end else if (!(hit && pend_v_reg && !out_free)) begin
                        if (hit) begin
                            pend_reg   <= node_reg;
                            pend_v_reg <= 1'b1;
                            n_reg      <= n_reg + 1'b1;
                        end
                        if (node_reg != tail_rd_reg) begin
                            node_reg <= link_rd_reg;
                        end else if (!row_end) begin
                            iy_reg <= iy_reg + 1'b1;
                            state_reg <= ST_CELL;
                        end else if (!col_end) begin
                            iy_reg   <= y0_reg;
                            ix_reg   <= ix_reg + 1'b1;
                            base_reg <= base_reg + CAW'(GRID_ROWS);
                            state_reg <= ST_CELL;
                        end else begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    res_reg.hit_valid <= pend_v_reg;
                    res_reg.hit_index <= pend_v_reg ? 10'(pend_reg) : 10'd0;
                    res_reg.truncated <= more_reg;
                    state_reg <= ST_EMIT;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result ports
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {4'b0, out_reg.truncated, out_reg.hit_index, out_reg.hit_valid,
                       out_reg.cell_y, out_reg.cell_x, out_reg.store_full,
                       out_reg.in_grid, out_reg.key_index};

endmodule
